// ===== hdl/sscd_pkg.sv =====
// Shared types, constants and table functions for the six-step commutation duty block.
// Used by sscd_front, sscd_queue, sscd_back and the top level; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package sscd_pkg;

    // Q1.15 full-scale duty
    localparam logic [15:0] FULL_DUTY       = 16'h8000;
    // the 16-step restoring division is spread over four stages of four steps
    localparam int          DIV_STAGES      = 4;
    localparam int          STEPS_PER_STAGE = 4;

    typedef enum logic [1:0] {
        PH_A = 2'd0,
        PH_B = 2'd1,
        PH_C = 2'd2
    } t_phase;

    // duty class decided up front; only CLS_DIV needs the quotient
    typedef enum logic [1:0] {
        CLS_ZERO = 2'd0,
        CLS_SAT  = 2'd1,
        CLS_DIV  = 2'd2
    } t_cls;

    // one classified transaction as it sits in the queue
    typedef struct packed {
        t_cls               cls;
        logic [2:0]         sidx;
        logic               neg;
        logic [15:0]        mag;
        logic [15:0]        udc;
        logic signed [15:0] cur;
    } t_item;

    // payload of one divider stage
    typedef struct packed {
        t_cls               cls;
        logic [2:0]         sidx;
        logic               neg;
        logic [15:0]        udc;
        logic signed [15:0] cur;
        logic [15:0]        rem;
        logic [15:0]        quo;
    } t_stage;

    // sector index 0..5 = floor(angle * 6 / 65536)
    function automatic logic [2:0] sector_idx(input logic [15:0] angle);
        logic [18:0] prod;
        begin
            prod = {1'b0, angle, 2'b00} + {2'b00, angle, 1'b0};
            if (prod[18:16] > 3'd5) begin
                sector_idx = 3'd5;
            end else begin
                sector_idx = prod[18:16];
            end
        end
    endfunction

    // phase that carries the duty, by sector and sign of the reference
    function automatic t_phase drive_phase(input logic [2:0] sidx, input logic neg);
        begin
            case (sidx)
                3'd0:    drive_phase = neg ? PH_A : PH_C;
                3'd1:    drive_phase = neg ? PH_B : PH_C;
                3'd2:    drive_phase = neg ? PH_B : PH_A;
                3'd3:    drive_phase = neg ? PH_C : PH_A;
                3'd4:    drive_phase = neg ? PH_C : PH_B;
                default: drive_phase = neg ? PH_A : PH_B;
            endcase
        end
    endfunction

    // tristated phase per sector
    function automatic t_phase float_phase(input logic [2:0] sidx);
        begin
            case (sidx)
                3'd0, 3'd3: float_phase = PH_B;
                3'd1, 3'd4: float_phase = PH_A;
                default:    float_phase = PH_C;
            endcase
        end
    endfunction

    // phase whose current is reported per sector
    function automatic t_phase current_phase(input logic [2:0] sidx);
        begin
            case (sidx)
                3'd0, 3'd1: current_phase = PH_C;
                3'd2, 3'd3: current_phase = PH_A;
                default:    current_phase = PH_B;
            endcase
        end
    endfunction

    // one restoring step: {next remainder, quotient bit}; needs rem < udc
    function automatic logic [16:0] div_step(input logic [15:0] rem,
                                             input logic [15:0] udc);
        logic [16:0] t;
        logic [16:0] diff;
        begin
            t    = {rem, 1'b0};
            diff = t - {1'b0, udc};
            if (t >= {1'b0, udc}) begin
                div_step = {diff[15:0], 1'b1};
            end else begin
                div_step = {t[15:0], 1'b0};
            end
        end
    endfunction

endpackage

`default_nettype wire

// ===== hdl/sscd_front.sv =====
// Front end: accepts input transactions and classifies them (sector, magnitude,
// duty class, active current). Depends on sscd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sscd_front import sscd_pkg::*; (
    input  wire logic               i_valid,
    input  wire logic               i_full,
    input  wire logic [15:0]        i_angle,
    input  wire logic signed [15:0] i_voltage_ref,
    input  wire logic [15:0]        i_dc_link_voltage,
    input  wire logic signed [15:0] i_current_a,
    input  wire logic signed [15:0] i_current_b,
    input  wire logic signed [15:0] i_current_c,
    output logic                    o_stall,
    output logic                    o_push,
    output t_item                   o_item
);

    logic [15:0] u_raw;
    logic        neg;
    logic [15:0] mag;
    logic [2:0]  sidx;

    // hold off the source while the queue is full
    assign o_stall = i_full;
    assign o_push  = i_valid && !i_full;

    // magnitude of the reference; the most negative code maps to full scale
    assign u_raw = $unsigned(i_voltage_ref);
    assign neg   = u_raw[15];
    assign mag   = neg ? (16'd0 - u_raw) : u_raw;
    assign sidx  = sector_idx(i_angle);

    // classify the duty and pick the active current
    always_comb begin
        o_item.sidx = sidx;
        o_item.neg  = neg;
        o_item.mag  = mag;
        o_item.udc  = i_dc_link_voltage;
        if (mag == 16'd0) begin
            o_item.cls = CLS_ZERO;
        end else if ({mag, 1'b0} >= {1'b0, i_dc_link_voltage}) begin
            o_item.cls = CLS_SAT;
        end else begin
            o_item.cls = CLS_DIV;
        end
        case (current_phase(sidx))
            PH_A:    o_item.cur = i_current_a;
            PH_B:    o_item.cur = i_current_b;
            default: o_item.cur = i_current_c;
        endcase
    end

endmodule

`default_nettype wire

// ===== hdl/sscd_queue.sv =====
// Short queue between the front end and the divider back end.
// Depends on sscd_pkg for the transaction type.
`timescale 1ns / 1ps
`default_nettype none

module sscd_queue import sscd_pkg::*; #(
    parameter int DEPTH = 4
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_push,
    input  wire t_item i_item,
    input  wire logic  i_pop,
    output logic       o_full,
    output logic       o_empty,
    output t_item      o_head
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_item            r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_head  = r_mem[r_rd_ptr];

    // advance pointers with wrap, track fill level
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // store the pushed transaction
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/sscd_back.sv =====
// Back end: pipelined restoring divider for the duty, commutation table and
// output register. Depends on sscd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sscd_back import sscd_pkg::*; (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_empty,
    input  wire t_item              i_head,
    output logic                    o_pop,
    input  wire logic               i_stall,
    output logic                    o_valid,
    output logic [2:0]              o_sector_number,
    output logic [15:0]             o_duty_phase_a,
    output logic [15:0]             o_duty_phase_b,
    output logic [15:0]             o_duty_phase_c,
    output logic                    o_float_phase_a,
    output logic                    o_float_phase_b,
    output logic                    o_float_phase_c,
    output logic signed [15:0]      o_active_current
);

    logic               adv;
    t_stage             w_in  [DIV_STAGES];
    logic               w_vld [DIV_STAGES];
    t_stage             n_stg [DIV_STAGES];
    t_stage             r_stg [DIV_STAGES];
    logic               r_vld [DIV_STAGES];

    logic               r_out_vld;
    logic [2:0]         r_sector;
    logic [15:0]        r_duty_a, r_duty_b, r_duty_c;
    logic               r_flt_a, r_flt_b, r_flt_c;
    logic signed [15:0] r_cur;

    t_stage             last;
    logic [15:0]        duty;
    t_phase             drv;
    t_phase             flt;

    // whole pipeline moves when the output register is free or being taken
    assign adv   = !r_out_vld || !i_stall;
    assign o_pop = adv && !i_empty;

    genvar g;
    generate
        for (g = 0; g < DIV_STAGES; g++) begin : g_stage
            if (g == 0) begin : g_first
                always_comb begin
                    w_vld[g]     = o_pop;
                    w_in[g].cls  = i_head.cls;
                    w_in[g].sidx = i_head.sidx;
                    w_in[g].neg  = i_head.neg;
                    w_in[g].udc  = i_head.udc;
                    w_in[g].cur  = i_head.cur;
                    w_in[g].rem  = i_head.mag;
                    w_in[g].quo  = '0;
                end
            end else begin : g_next
                assign w_vld[g] = r_vld[g-1];
                assign w_in[g]  = r_stg[g-1];
            end

            // four division steps per stage
            always_comb begin
                logic [16:0] st;
                n_stg[g] = w_in[g];
                for (int k = 0; k < STEPS_PER_STAGE; k++) begin
                    st           = div_step(n_stg[g].rem, n_stg[g].udc);
                    n_stg[g].rem = st[16:1];
                    n_stg[g].quo = {n_stg[g].quo[14:0], st[0]};
                end
            end

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_vld[g] <= 1'b0;
                end else if (adv) begin
                    r_vld[g] <= w_vld[g];
                end
            end

            always_ff @(posedge i_clk) begin
                if (adv) begin
                    r_stg[g] <= n_stg[g];
                end
            end
        end
    endgenerate

    // pick the duty and place it by the six-step table
    assign last = r_stg[DIV_STAGES-1];
    always_comb begin
        case (last.cls)
            CLS_ZERO: duty = '0;
            CLS_SAT:  duty = FULL_DUTY;
            default:  duty = last.quo;
        endcase
        drv = drive_phase(last.sidx, last.neg);
        flt = float_phase(last.sidx);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (adv) begin
            r_out_vld <= r_vld[DIV_STAGES-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_sector <= last.sidx + 3'd1;
            r_duty_a <= (drv == PH_A) ? duty : 16'd0;
            r_duty_b <= (drv == PH_B) ? duty : 16'd0;
            r_duty_c <= (drv == PH_C) ? duty : 16'd0;
            r_flt_a  <= (flt == PH_A);
            r_flt_b  <= (flt == PH_B);
            r_flt_c  <= (flt == PH_C);
            r_cur    <= last.cur;
        end
    end

    assign o_valid          = r_out_vld;
    assign o_sector_number  = r_sector;
    assign o_duty_phase_a   = r_duty_a;
    assign o_duty_phase_b   = r_duty_b;
    assign o_duty_phase_c   = r_duty_c;
    assign o_float_phase_a  = r_flt_a;
    assign o_float_phase_b  = r_flt_b;
    assign o_float_phase_c  = r_flt_c;
    assign o_active_current = r_cur;

endmodule

`default_nettype wire

// ===== hdl/six_step_commutation_duty_top.sv =====
// Six-step commutation with duty normalisation: front end, queue and divider back end.
// Depends on sscd_pkg, sscd_front, sscd_queue and sscd_back.
//
// Takes one transaction per clock cycle when not stalled. Each accepted transaction
// passes through the queue write, four divider stages and the output register; the
// 16-step restoring division of 2|u|/Udc runs four steps per stage. o_stall rises
// only when QUEUE_DEPTH transactions wait in the queue, which happens when i_stall
// holds the output back. Duty is Q1.15, saturated at 32768.
`timescale 1ns / 1ps
`default_nettype none

module six_step_commutation_duty_top import sscd_pkg::*; #(
    parameter int QUEUE_DEPTH = 4
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_stall,
    input  wire logic [15:0]        i_angle,
    input  wire logic signed [15:0] i_voltage_ref,
    input  wire logic [15:0]        i_dc_link_voltage,
    input  wire logic signed [15:0] i_current_a,
    input  wire logic signed [15:0] i_current_b,
    input  wire logic signed [15:0] i_current_c,
    output logic                    o_valid,
    input  wire logic               i_stall,
    output logic [2:0]              o_sector_number,
    output logic [15:0]             o_duty_phase_a,
    output logic [15:0]             o_duty_phase_b,
    output logic [15:0]             o_duty_phase_c,
    output logic                    o_float_phase_a,
    output logic                    o_float_phase_b,
    output logic                    o_float_phase_c,
    output logic signed [15:0]      o_active_current
);

    logic  push, pop, full, empty;
    t_item item, head;

    // classify incoming transactions
    sscd_front u_front (
        .i_valid           (i_valid),
        .i_full            (full),
        .i_angle           (i_angle),
        .i_voltage_ref     (i_voltage_ref),
        .i_dc_link_voltage (i_dc_link_voltage),
        .i_current_a       (i_current_a),
        .i_current_b       (i_current_b),
        .i_current_c       (i_current_c),
        .o_stall           (o_stall),
        .o_push            (push),
        .o_item            (item)
    );

    // decouple front and back
    sscd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (item),
        .i_pop   (pop),
        .o_full  (full),
        .o_empty (empty),
        .o_head  (head)
    );

    // divide, place the duty and register the result
    sscd_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_empty          (empty),
        .i_head           (head),
        .o_pop            (pop),
        .i_stall          (i_stall),
        .o_valid          (o_valid),
        .o_sector_number  (o_sector_number),
        .o_duty_phase_a   (o_duty_phase_a),
        .o_duty_phase_b   (o_duty_phase_b),
        .o_duty_phase_c   (o_duty_phase_c),
        .o_float_phase_a  (o_float_phase_a),
        .o_float_phase_b  (o_float_phase_b),
        .o_float_phase_c  (o_float_phase_c),
        .o_active_current (o_active_current)
    );

endmodule

`default_nettype wire

// ===== hdl/sscd_checker.sv =====
// Port-level checks on the result channel of the six-step commutation block,
// bound to six_step_commutation_duty_top. No package dependency.
`timescale 1ns / 1ps
`default_nettype none

module sscd_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        o_valid,
    input wire logic        i_stall,
    input wire logic [2:0]  o_sector_number,
    input wire logic [15:0] o_duty_phase_a,
    input wire logic [15:0] o_duty_phase_b,
    input wire logic [15:0] o_duty_phase_c,
    input wire logic        o_float_phase_a,
    input wire logic        o_float_phase_b,
    input wire logic        o_float_phase_c
);

    // a stalled transaction stays and holds its sector and duties
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_sector_number)
            && $stable(o_duty_phase_a) && $stable(o_duty_phase_b)
            && $stable(o_duty_phase_c))
        else $error("stalled result changed");

    // exactly one phase floats
    a_one_float: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $onehot({o_float_phase_a, o_float_phase_b, o_float_phase_c}))
        else $error("float phases not one-hot");

    // the floating phase follows the sector
    a_float_sector: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_float_phase_b == (o_sector_number == 3'd1 || o_sector_number == 3'd4))
            && (o_float_phase_a == (o_sector_number == 3'd2 || o_sector_number == 3'd5)))
        else $error("float phase disagrees with sector");

    // at most one phase driven, never the floating one, never above full scale
    a_duty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $onehot0({o_duty_phase_a != 16'd0, o_duty_phase_b != 16'd0,
                              o_duty_phase_c != 16'd0})
            && (!o_float_phase_a || o_duty_phase_a == 16'd0)
            && (!o_float_phase_b || o_duty_phase_b == 16'd0)
            && (!o_float_phase_c || o_duty_phase_c == 16'd0)
            && o_duty_phase_a <= 16'h8000 && o_duty_phase_b <= 16'h8000
            && o_duty_phase_c <= 16'h8000)
        else $error("duty placement wrong");

    // sector stays in range
    a_sector: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_sector_number >= 3'd1 && o_sector_number <= 3'd6)
        else $error("sector out of range");

endmodule

bind six_step_commutation_duty_top sscd_checker u_sscd_checker (.*);

`default_nettype wire
